FILE: rtl/ntpc_pkg.sv
// ----------------------------------------------------------------------------
// NTP calendar package
// Shared types, constants and the month length table for the NTP seconds to
// UTC calendar converter.
// ----------------------------------------------------------------------------
package ntpc_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [DataW-1:0] NTP_UNIX_OFFSET = 32'd2208988800;
  localparam logic [10:0]      EPOCH_YEAR      = 11'd1970;

  // Divisors are preshifted so that the first restoring step tests the
  // highest quotient bit.
  localparam logic [DataW-1:0] DAY_DIV_INIT   = 32'd86400 << 14;
  localparam logic [DataW-1:0] HOUR_DIV_INIT  = 32'd3600 << 4;
  localparam logic [DataW-1:0] MIN_DIV_INIT   = 32'd60 << 5;
  localparam logic [DataW-1:0] BLOCK_DIV_INIT = 32'd1461 << 4;

  localparam logic [3:0] DAY_STEPS_LAST   = 4'd14;
  localparam logic [3:0] HOUR_STEPS_LAST  = 4'd4;
  localparam logic [3:0] MIN_STEPS_LAST   = 4'd5;
  localparam logic [3:0] BLOCK_STEPS_LAST = 4'd4;

  localparam logic [3:0] MONTH_FEB  = 4'd1;
  localparam logic [3:0] MONTH_APR  = 4'd3;
  localparam logic [3:0] MONTH_JUN  = 4'd5;
  localparam logic [3:0] MONTH_SEP  = 4'd8;
  localparam logic [3:0] MONTH_NOV  = 4'd10;
  localparam logic [3:0] MONTH_DEC  = 4'd11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFSET,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_DIV_BLOCK,
    ST_YEAR,
    ST_MONTH
  } state_t;

  typedef struct packed {
    logic             ge;
    logic [DataW-1:0] diff;
  } sub_result_t;

  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    case (idx) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/ntpc_sub_unit.sv
// ----------------------------------------------------------------------------
// NTP calendar compare and subtract unit
// One 32-bit subtractor whose borrow gives the compare result; it serves
// every division, year and month step of the converter.
// ----------------------------------------------------------------------------
module ntpc_sub_unit
  import ntpc_pkg::*;
(
  input  logic [DataW-1:0] a,
  input  logic [DataW-1:0] b,
  output sub_result_t      res
);

  logic [DataW:0] full;

  assign full     = {1'b0, a} - {1'b0, b};
  assign res.diff = full[DataW-1:0];
  assign res.ge   = ~full[DataW];

endmodule

FILE: rtl/ntp_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// NTP seconds to UTC calendar converter
// Converts the seconds field of an NTP timestamp into UTC year, month, day,
// hour, minute and second, clamping times before 1970 to the epoch.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. The result
// appears with done high for one cycle. The single compare and subtract
// unit carries out every step in turn: the epoch offset, 31 restoring
// division steps for days, hours, minutes and four-year blocks, then one
// step per year and per month walked. The receiver cannot stall, and busy
// is low again in the cycle that done is high.
module ntp_seconds_to_calendar_core
  import ntpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] ntp_seconds,
  output logic        done,
  output logic [10:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic        before_epoch
);

  state_t           state, state_next;
  logic [DataW-1:0] acc, acc_next;
  logic [DataW-1:0] dvs, dvs_next;
  logic [14:0]      quo, quo_next;
  logic [3:0]       cnt, cnt_next;
  logic [14:0]      days, days_next;
  logic [4:0]       hour_r, hour_r_next;
  logic [5:0]       minute_r, minute_r_next;
  logic [5:0]       second_r, second_r_next;
  logic [10:0]      year_r, year_r_next;
  logic [3:0]       mon, mon_next;
  logic             flag, flag_next;
  logic             load_out;

  logic [DataW-1:0] op_b;
  sub_result_t      sub;
  logic [14:0]      quo_step;
  logic [DataW-1:0] acc_step;
  logic             leap;

  ntpc_sub_unit u_sub (
    .a   (acc),
    .b   (op_b),
    .res (sub)
  );

  assign leap     = (year_r[1:0] == 2'b00);
  assign quo_step = {quo[13:0], sub.ge};
  assign acc_step = sub.ge ? sub.diff : acc;
  assign busy     = (state != ST_IDLE);

  always_comb begin
    case (state)
      ST_OFFSET: op_b = NTP_UNIX_OFFSET;
      ST_YEAR:   op_b = leap ? 32'd366 : 32'd365;
      ST_MONTH:  op_b = {27'd0, month_len(mon, leap)};
      default:   op_b = dvs;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    acc      <= acc_next;
    dvs      <= dvs_next;
    quo      <= quo_next;
    cnt      <= cnt_next;
    days     <= days_next;
    hour_r   <= hour_r_next;
    minute_r <= minute_r_next;
    second_r <= second_r_next;
    year_r   <= year_r_next;
    mon      <= mon_next;
    flag     <= flag_next;
    if (load_out) begin
      year         <= year_r;
      month        <= mon + 4'd1;
      day          <= acc[4:0] + 5'd1;
      hour         <= hour_r;
      minute       <= minute_r;
      second       <= second_r;
      before_epoch <= flag;
    end
  end

  always_comb begin
    state_next    = state;
    acc_next      = acc;
    dvs_next      = dvs;
    quo_next      = quo;
    cnt_next      = cnt;
    days_next     = days;
    hour_r_next   = hour_r;
    minute_r_next = minute_r;
    second_r_next = second_r;
    year_r_next   = year_r;
    mon_next      = mon;
    flag_next     = flag;
    load_out      = 1'b0;

    if (state == ST_DIV_DAY || state == ST_DIV_HOUR ||
        state == ST_DIV_MIN || state == ST_DIV_BLOCK) begin
      acc_next = acc_step;
      quo_next = quo_step;
      dvs_next = dvs >> 1;
      cnt_next = cnt - 4'd1;
    end

    case (state)
      ST_IDLE: begin
        if (start) begin
          acc_next   = ntp_seconds;
          flag_next  = 1'b0;
          state_next = ST_OFFSET;
        end
      end
      ST_OFFSET: begin
        acc_next   = sub.ge ? sub.diff : '0;
        flag_next  = ~sub.ge;
        dvs_next   = DAY_DIV_INIT;
        cnt_next   = DAY_STEPS_LAST;
        quo_next   = '0;
        state_next = ST_DIV_DAY;
      end
      ST_DIV_DAY: begin
        if (cnt == 4'd0) begin
          days_next  = quo_step;
          dvs_next   = HOUR_DIV_INIT;
          cnt_next   = HOUR_STEPS_LAST;
          quo_next   = '0;
          state_next = ST_DIV_HOUR;
        end
      end
      ST_DIV_HOUR: begin
        if (cnt == 4'd0) begin
          hour_r_next = quo_step[4:0];
          dvs_next    = MIN_DIV_INIT;
          cnt_next    = MIN_STEPS_LAST;
          quo_next    = '0;
          state_next  = ST_DIV_MIN;
        end
      end
      ST_DIV_MIN: begin
        if (cnt == 4'd0) begin
          minute_r_next = quo_step[5:0];
          second_r_next = acc_step[5:0];
          acc_next      = {17'd0, days};
          dvs_next      = BLOCK_DIV_INIT;
          cnt_next      = BLOCK_STEPS_LAST;
          quo_next      = '0;
          state_next    = ST_DIV_BLOCK;
        end
      end
      ST_DIV_BLOCK: begin
        if (cnt == 4'd0) begin
          year_r_next = EPOCH_YEAR + {4'd0, quo_step[4:0], 2'b00};
          state_next  = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sub.ge) begin
          acc_next    = sub.diff;
          year_r_next = year_r + 11'd1;
        end else begin
          mon_next   = '0;
          state_next = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (mon == MONTH_DEC || !sub.ge) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          acc_next = sub.diff;
          mon_next = mon + 4'd1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/sv/tb_ntp_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// NTP seconds to UTC calendar converter testbench
// Sends NTP seconds values, including times before 1970, leap days, year and
// four-year block boundaries and the top of the 32-bit range, then random
// values under three sender idle settings. Every result is checked field by
// field against a calendar predictor that runs alongside the block.
// ----------------------------------------------------------------------------
module tb_ntp_seconds_to_calendar_core;
  import ntpc_pkg::*;

  localparam int unsigned SecsPerDay   = 86400;
  localparam int unsigned LastDay      = 24142;
  localparam int unsigned DrainCycles  = 60;
  localparam int unsigned CycleLimit   = 200000;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        before_epoch;
  } calendar_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] ntp_seconds = '0;
  logic        done;
  logic [10:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        before_epoch;

  calendar_t   pending_dates[$];
  int unsigned mismatch_count = 0;
  int unsigned sender_idle_pct = 0;

  ntp_seconds_to_calendar_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .ntp_seconds  (ntp_seconds),
    .done         (done),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .before_epoch (before_epoch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic calendar_t calendar_of(input logic [31:0] ntp);
    calendar_t   c;
    logic [31:0] t;
    int unsigned days;
    int unsigned rem;
    int unsigned yr;
    int unsigned ylen;
    int unsigned mlen;
    logic [3:0]  mon;
    logic        walking;
    c.before_epoch = (ntp < NTP_UNIX_OFFSET);
    t = c.before_epoch ? 32'd0 : ntp - NTP_UNIX_OFFSET;
    c.second = 6'(t % 60);
    c.minute = 6'((t / 60) % 60);
    c.hour   = 5'((t / 3600) % 24);
    days = t / SecsPerDay;
    yr   = 1970 + 4 * (days / 1461);
    rem  = days % 1461;
    walking = 1'b1;
    for (int i = 0; i < 4; i++) begin
      ylen = (yr % 4 == 0) ? 366 : 365;
      if (walking && rem >= ylen) begin
        rem -= ylen;
        yr++;
      end else begin
        walking = 1'b0;
      end
    end
    mon = 4'd0;
    walking = 1'b1;
    for (int i = 0; i < 11; i++) begin
      if (mon == MONTH_FEB) begin
        mlen = (yr % 4 == 0) ? 29 : 28;
      end else if (mon == MONTH_APR || mon == MONTH_JUN || mon == MONTH_SEP ||
                   mon == MONTH_NOV) begin
        mlen = 30;
      end else begin
        mlen = 31;
      end
      if (walking && rem >= mlen) begin
        rem -= mlen;
        mon++;
      end else begin
        walking = 1'b0;
      end
    end
    c.year  = 11'(yr);
    c.month = mon + 4'd1;
    c.day   = 5'(rem + 1);
    return c;
  endfunction

  function automatic logic [31:0] ntp_at(input int unsigned day_num,
                                         input int unsigned sec_of_day);
    return NTP_UNIX_OFFSET + 32'(day_num * SecsPerDay + sec_of_day);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Called in the time step of a rising edge. Returns in the step of the edge
  // that accepted the transaction, with start still high.
  task automatic send_timestamp(input logic [31:0] value);
    logic idle;
    logic accepted;
    accepted = 1'b0;
    while (!accepted) begin
      idle = ($urandom_range(99) < sender_idle_pct);
      start <= !idle;
      ntp_seconds <= idle ? $urandom : value;
      @(posedge clk);
      if (!idle && !busy) begin
        accepted = 1'b1;
      end
    end
    pending_dates.push_back(calendar_of(value));
  endtask

  always @(posedge clk) begin
    calendar_t want;
    if (!rst && done) begin
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("result %0d-%0d-%0d with no transaction pending",
                                  year, month, day));
      end else begin
        want = pending_dates.pop_front();
        if (year !== want.year)
          report_mismatch($sformatf("year expected %0d, got %0d", want.year, year));
        if (month !== want.month)
          report_mismatch($sformatf("month expected %0d, got %0d", want.month, month));
        if (day !== want.day)
          report_mismatch($sformatf("day expected %0d, got %0d", want.day, day));
        if (hour !== want.hour)
          report_mismatch($sformatf("hour expected %0d, got %0d", want.hour, hour));
        if (minute !== want.minute)
          report_mismatch($sformatf("minute expected %0d, got %0d", want.minute, minute));
        if (second !== want.second)
          report_mismatch($sformatf("second expected %0d, got %0d", want.second, second));
        if (before_epoch !== want.before_epoch)
          report_mismatch($sformatf("before_epoch expected %0b, got %0b",
                                    want.before_epoch, before_epoch));
      end
    end
  end

  task automatic test_before_epoch();
    send_timestamp(32'd0);
    send_timestamp(32'd1);
    send_timestamp(32'h5555_AAAA);
    send_timestamp(NTP_UNIX_OFFSET - 32'd1);
  endtask

  task automatic test_epoch_and_upper_end();
    send_timestamp(NTP_UNIX_OFFSET);
    send_timestamp(ntp_at(0, SecsPerDay - 1));
    send_timestamp(32'hFFFF_FFFE);
    send_timestamp(32'hFFFF_FFFF);
  endtask

  task automatic test_leap_day();
    send_timestamp(ntp_at(788, SecsPerDay - 1));
    send_timestamp(ntp_at(789, 0));
    send_timestamp(ntp_at(789, SecsPerDay - 1));
    send_timestamp(ntp_at(790, 0));
    send_timestamp(ntp_at(11016, 43210));
    send_timestamp(ntp_at(423, SecsPerDay - 1));
    send_timestamp(ntp_at(424, 0));
  endtask

  task automatic test_year_boundaries();
    send_timestamp(ntp_at(364, SecsPerDay - 1));
    send_timestamp(ntp_at(365, 0));
    send_timestamp(ntp_at(1095, SecsPerDay - 1));
    send_timestamp(ntp_at(1096, 0));
    send_timestamp(ntp_at(1460, SecsPerDay - 1));
    send_timestamp(ntp_at(1461, 0));
    send_timestamp(ntp_at(24106, 0));
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned count);
    int unsigned pick;
    int unsigned sec_of_day;
    logic [31:0] value;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      pick = $urandom_range(9);
      if (pick < 2) begin
        value = $urandom_range(NTP_UNIX_OFFSET - 1, 0);
      end else if (pick < 5) begin
        case ($urandom_range(2))
          0:       sec_of_day = 0;
          1:       sec_of_day = SecsPerDay - 1;
          default: sec_of_day = $urandom_range(SecsPerDay - 1);
        endcase
        value = ntp_at($urandom_range(LastDay), sec_of_day);
      end else if (pick < 6) begin
        value = $urandom;
      end else begin
        value = $urandom_range(32'hFFFF_FFFF, NTP_UNIX_OFFSET);
      end
      send_timestamp(value);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_idle_pct = 6;
    test_before_epoch();
    test_epoch_and_upper_end();
    test_leap_day();
    test_year_boundaries();
    test_random(6, 130);
    test_random(79, 130);
    test_random(0, 140);
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    for (int unsigned cycle = 0; cycle < CycleLimit; cycle++) @(posedge clk);
    $display("timeout after %0d cycles", CycleLimit);
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: ntp_seconds_to_calendar_core.f
rtl/ntpc_pkg.sv
rtl/ntpc_sub_unit.sv
rtl/ntp_seconds_to_calendar_core.sv
tb/sv/tb_ntp_seconds_to_calendar_core.sv
